// File: hw/rtl/supply_battery_power_state_monitor_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the supply/battery power state monitor
// Shared property forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_BATTERY_POWER_STATE_MONITOR_MACROS_SVH
`define SUPPLY_BATTERY_POWER_STATE_MONITOR_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define SBPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the same cycle as the antecedent
`define SBPSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sbpsm_pkg.sv
// ----------------------------------------------------------------------------
// sbpsm_pkg
// Types and constants of the supply/battery power state monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbpsm_pkg;

  typedef enum logic [2:0] {
    ST_STARTUP  = 3'd0,
    ST_NORMAL   = 3'd1,
    ST_LOWBAT   = 3'd2,
    ST_ERROR    = 3'd3,
    ST_SHUTDOWN = 3'd4
  } power_state_t;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_SHUTDOWN = 2'd1,
    KIND_MODEM    = 2'd2,
    KIND_SWITCH   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SUPPLY_MIN  = 3'd0,
    REG_SUPPLY_MAX  = 3'd1,
    REG_BATTERY_MIN = 3'd2,
    REG_BATTERY_MAX = 3'd3,
    REG_TEMP_LIMIT  = 3'd4,
    REG_TICK_PERIOD = 3'd5
  } reg_idx_t;

  typedef struct packed {
    power_state_t state;
    logic         charging;
    logic         voltage_ok;
    logic         temperature_ok;
    logic         modem_on;
    logic         switch_on;
  } status_t;

  localparam logic [15:0]       SUPPLY_MIN_RST  = 16'd9000;
  localparam logic [15:0]       SUPPLY_MAX_RST  = 16'd16000;
  localparam logic [15:0]       BATTERY_MIN_RST = 16'd3300;
  localparam logic [15:0]       BATTERY_MAX_RST = 16'd4300;
  localparam logic signed [7:0] TEMP_LIMIT_RST  = 8'sd85;
  localparam logic [15:0]       TICK_PERIOD_RST = 16'd100;

  localparam logic [16:0] CHARGE_STEP_MV    = 17'd50;
  localparam logic [16:0] RECOVER_MARGIN_MV = 17'd200;

  // x / 1000 == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int          RECIP_W     = 29;
  localparam logic [28:0] RECIP_MUL   = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;
  localparam int          QUOT_W      = 23;

endpackage

`default_nettype wire

// File: hw/rtl/supply_battery_power_state_monitor.sv
// ----------------------------------------------------------------------------
// supply_battery_power_state_monitor
// Power state machine driven by supply, battery and temperature samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one request per cycle while
//   in_stall is low: a tick with samples, a shutdown, or a modem / switch
//   level set. Each request yields one status result on the output channel
//   (out_valid / out_stall). Configuration writes (cfg_valid / cfg_ready,
//   cfg_index, cfg_data) are always ready; the user must see that they are
//   taken only while the block is idle, which the block does not enforce.
//   Three register stages; out_valid and the result come from stage 3;
//   throughput is one request per cycle while out_stall is low. The state
//   update is registered on acceptance; the uptime goes through a 32x16
//   multiply stage and a reciprocal multiply stage for the /1000.
//   When out_stall holds, stages fill up one by one and in_stall rises only
//   once all three are occupied; results are never dropped or duplicated.
//   Reset returns the thresholds to their defaults, the state to startup,
//   counts and flags to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "supply_battery_power_state_monitor_macros.svh"

module supply_battery_power_state_monitor
  import sbpsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [15:0]        in_supply_mv,
  input  wire logic [15:0]        in_battery_mv,
  input  wire logic signed [7:0]  in_temperature_c,
  input  wire logic               in_enable,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_power_state,
  output logic                    out_charging,
  output logic                    out_voltage_ok,
  output logic                    out_temperature_ok,
  output logic                    out_modem_on,
  output logic                    out_switch_on,
  output logic [31:0]             out_uptime_s,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // configuration
  logic [15:0]       sup_min_r, sup_max_r, bat_min_r, bat_max_r, period_r;
  logic signed [7:0] temp_lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_min_r  <= SUPPLY_MIN_RST;
      sup_max_r  <= SUPPLY_MAX_RST;
      bat_min_r  <= BATTERY_MIN_RST;
      bat_max_r  <= BATTERY_MAX_RST;
      temp_lim_r <= TEMP_LIMIT_RST;
      period_r   <= TICK_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SUPPLY_MIN:  sup_min_r  <= cfg_data;
        REG_SUPPLY_MAX:  sup_max_r  <= cfg_data;
        REG_BATTERY_MIN: bat_min_r  <= cfg_data;
        REG_BATTERY_MAX: bat_max_r  <= cfg_data;
        REG_TEMP_LIMIT:  temp_lim_r <= cfg_data[7:0];
        REG_TICK_PERIOD: period_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3, in_acc;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign in_acc   = in_valid && !in_stall;

  // monitor state
  power_state_t mode_r, mode_nxt;
  logic [31:0]  tick_cnt_r, tick_cnt_nxt;
  logic [15:0]  prev_bat_r, prev_bat_nxt;
  logic [15:0]  up_period_r, up_period_nxt;
  logic         chg_r, chg_nxt, vok_r, vok_nxt, tok_r, tok_nxt;
  logic         modem_r, modem_nxt, switch_r, switch_nxt;

  logic         is_tick, tick_chg, tick_vok, tick_tok, bat_low, bat_recov;

  assign is_tick   = (kind_t'(in_kind) == KIND_TICK);
  assign tick_chg  = {1'b0, in_battery_mv} > ({1'b0, prev_bat_r} + CHARGE_STEP_MV);
  assign tick_vok  = (in_supply_mv >= sup_min_r) && (in_supply_mv <= sup_max_r) &&
                     (in_battery_mv >= bat_min_r) && (in_battery_mv <= bat_max_r);
  assign tick_tok  = in_temperature_c < temp_lim_r;
  assign bat_low   = in_battery_mv < bat_min_r;
  assign bat_recov = {1'b0, in_battery_mv} > ({1'b0, bat_min_r} + RECOVER_MARGIN_MV);

  always_comb begin
    mode_nxt      = mode_r;
    tick_cnt_nxt  = tick_cnt_r;
    prev_bat_nxt  = prev_bat_r;
    up_period_nxt = up_period_r;
    chg_nxt       = chg_r;
    vok_nxt       = vok_r;
    tok_nxt       = tok_r;
    modem_nxt     = modem_r;
    switch_nxt    = switch_r;
    unique case (kind_t'(in_kind))
      KIND_TICK: begin
        tick_cnt_nxt  = tick_cnt_r + 32'd1;
        up_period_nxt = period_r;
        prev_bat_nxt  = in_battery_mv;
        chg_nxt       = tick_chg;
        vok_nxt       = tick_vok;
        tok_nxt       = tick_tok;
        unique case (mode_r)
          ST_STARTUP: mode_nxt = tick_vok ? ST_NORMAL : ST_ERROR;
          ST_NORMAL: begin
            if (!tick_vok || !tick_tok) mode_nxt = ST_ERROR;
            if (bat_low) mode_nxt = ST_LOWBAT;
          end
          ST_LOWBAT: begin
            if (tick_chg && bat_recov) mode_nxt = ST_NORMAL;
          end
          ST_SHUTDOWN: begin
            modem_nxt  = 1'b0;
            switch_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      KIND_SHUTDOWN: begin
        mode_nxt   = ST_SHUTDOWN;
        modem_nxt  = 1'b0;
        switch_nxt = 1'b0;
      end
      KIND_MODEM:  modem_nxt  = in_enable;
      KIND_SWITCH: switch_nxt = in_enable;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ST_STARTUP;
      tick_cnt_r  <= '0;
      prev_bat_r  <= '0;
      up_period_r <= '0;
      chg_r       <= 1'b0;
      vok_r       <= 1'b0;
      tok_r       <= 1'b0;
      modem_r     <= 1'b0;
      switch_r    <= 1'b0;
    end else if (in_acc) begin
      mode_r      <= mode_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      prev_bat_r  <= prev_bat_nxt;
      up_period_r <= up_period_nxt;
      chg_r       <= chg_nxt;
      vok_r       <= vok_nxt;
      tok_r       <= tok_nxt;
      modem_r     <= modem_nxt;
      switch_r    <= switch_nxt;
    end
  end

  // stage 1: status snapshot, tick count and period of last tick
  status_t     st1_r, st2_r, st3_r;
  logic [31:0] cnt1_r;
  logic [15:0] per1_r;

  // stage 2: wrapped product; stage 3: quotient by 1000
  logic [47:0]                 prod_full;
  logic [31:0]                 prod2_r;
  logic [RECIP_W+31:0]         recip_full;
  logic [31:0]                 up3_r;

  assign prod_full  = cnt1_r * per1_r;
  assign recip_full = prod2_r * RECIP_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_acc;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      st1_r  <= '{state: mode_nxt, charging: chg_nxt, voltage_ok: vok_nxt,
                  temperature_ok: tok_nxt, modem_on: modem_nxt, switch_on: switch_nxt};
      cnt1_r <= tick_cnt_nxt;
      per1_r <= up_period_nxt;
    end
    if (en2) begin
      st2_r   <= st1_r;
      prod2_r <= prod_full[31:0];
    end
    if (en3) begin
      st3_r <= st2_r;
      up3_r <= {{(32-QUOT_W){1'b0}}, recip_full[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT]};
    end
  end

  assign out_valid          = v3_r;
  assign out_power_state    = st3_r.state;
  assign out_charging       = st3_r.charging;
  assign out_voltage_ok     = st3_r.voltage_ok;
  assign out_temperature_ok = st3_r.temperature_ok;
  assign out_modem_on       = st3_r.modem_on;
  assign out_switch_on      = st3_r.switch_on;
  assign out_uptime_s       = up3_r;

  // assertions
  `SBPSM_ASSERT_NEXT(a_tick_count_step, in_acc && is_tick, tick_cnt_r == $past(tick_cnt_r) + 32'd1, "tick count did not advance by one")
  `SBPSM_ASSERT_NEXT(a_tick_count_hold, in_acc && !is_tick, $stable(tick_cnt_r), "tick count moved on a non-tick request")
  `SBPSM_ASSERT_NEXT(a_error_sticky, mode_r == ST_ERROR && !(in_acc && kind_t'(in_kind) == KIND_SHUTDOWN), mode_r == ST_ERROR, "error state left without shutdown")
  `SBPSM_ASSERT_NEXT(a_shutdown_tick_off, in_acc && is_tick && mode_r == ST_SHUTDOWN, !modem_r && !switch_r, "outputs on after tick in shutdown")
  `SBPSM_ASSERT_NOW(a_stall_full, in_stall, v1_r && v2_r && v3_r && out_stall, "input stalled with a free stage")

endmodule

`default_nettype wire

// File: test/tb_supply_battery_power_state_monitor.sv
// ----------------------------------------------------------------------------
// tb_supply_battery_power_state_monitor
// Self-checking bench: a status predictor tracks the power state machine,
// the windows, charging and uptime for every accepted request and compares
// each result in order. Directed requests, then random phases with varied
// thresholds, sender idling, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_supply_battery_power_state_monitor;
  import sbpsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 64;
  localparam int PIPE_LATENCY   = 3;

  // indexes past the last register; writes there are dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    power_state_t state;
    logic         charging;
    logic         voltage_ok;
    logic         temperature_ok;
    logic         modem_on;
    logic         switch_on;
    logic [31:0]  uptime_s;
  } monitor_status_t;

  typedef struct {
    logic [2:0]  index;
    logic [15:0] data;
  } reg_write_t;

  class monitor_status_board;
    logic [15:0]       supply_min, supply_max, battery_min, battery_max, period_ms;
    logic signed [7:0] temp_limit;
    power_state_t      mode;
    logic [31:0]       tick_total, uptime;
    logic [15:0]       last_battery;
    logic              charging, volt_ok, temp_ok, modem_on, switch_on;
    monitor_status_t   status_due[$];
    int unsigned       mismatches, results_seen;
    int unsigned       per_state[5];

    function new();
      supply_min   = SUPPLY_MIN_RST;
      supply_max   = SUPPLY_MAX_RST;
      battery_min  = BATTERY_MIN_RST;
      battery_max  = BATTERY_MAX_RST;
      temp_limit   = TEMP_LIMIT_RST;
      period_ms    = TICK_PERIOD_RST;
      mode         = ST_STARTUP;
      tick_total   = '0;
      uptime       = '0;
      last_battery = '0;
      charging     = 1'b0;
      volt_ok      = 1'b0;
      temp_ok      = 1'b0;
      modem_on     = 1'b0;
      switch_on    = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      foreach (per_state[i]) per_state[i] = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [15:0] data);
      case (index)
        REG_SUPPLY_MIN:  supply_min  = data;
        REG_SUPPLY_MAX:  supply_max  = data;
        REG_BATTERY_MIN: battery_min = data;
        REG_BATTERY_MAX: battery_max = data;
        REG_TEMP_LIMIT:  temp_limit  = data[7:0];
        REG_TICK_PERIOD: period_ms   = data;
        default: ;
      endcase
    endfunction

    function void take_request(kind_t kind, logic [15:0] vsup, logic [15:0] vbat,
                               logic signed [7:0] temp, logic en);
      monitor_status_t s;
      logic [31:0]     product;
      case (kind)
        KIND_TICK: begin
          tick_total   = tick_total + 32'd1;
          product      = tick_total * {16'd0, period_ms};
          uptime       = product / 32'd1000;
          charging     = (17'(vbat) > 17'(last_battery) + 17'd50);
          last_battery = vbat;
          volt_ok      = (vsup >= supply_min) && (vsup <= supply_max) &&
                         (vbat >= battery_min) && (vbat <= battery_max);
          temp_ok      = (temp < temp_limit);
          case (mode)
            ST_STARTUP: mode = volt_ok ? ST_NORMAL : ST_ERROR;
            ST_NORMAL: begin
              if (!volt_ok) mode = ST_ERROR;
              if (!temp_ok) mode = ST_ERROR;
              if (vbat < battery_min) mode = ST_LOWBAT;
            end
            ST_LOWBAT: begin
              if (charging && (17'(vbat) > 17'(battery_min) + 17'd200)) mode = ST_NORMAL;
            end
            ST_SHUTDOWN: begin
              modem_on  = 1'b0;
              switch_on = 1'b0;
            end
            default: ;
          endcase
        end
        KIND_SHUTDOWN: begin
          mode      = ST_SHUTDOWN;
          modem_on  = 1'b0;
          switch_on = 1'b0;
        end
        KIND_MODEM: modem_on = en;
        default:    switch_on = en;
      endcase
      s.state          = mode;
      s.charging       = charging;
      s.voltage_ok     = volt_ok;
      s.temperature_ok = temp_ok;
      s.modem_on       = modem_on;
      s.switch_on      = switch_on;
      s.uptime_s       = uptime;
      status_due.push_back(s);
    endfunction

    function void match_status(logic [2:0] st, logic chg, logic vok, logic tok,
                               logic mdm, logic swo, logic [31:0] up);
      monitor_status_t want;
      if (status_due.size() == 0) begin
        $error("status result with no request pending");
        mismatches++;
        return;
      end
      want = status_due.pop_front();
      results_seen++;
      per_state[int'(want.state)]++;
      if (st !== want.state) begin
        $error("power_state: expected %0d, got %0d", want.state, st);
        mismatches++;
      end
      if (chg !== want.charging) begin
        $error("charging: expected %0b, got %0b", want.charging, chg);
        mismatches++;
      end
      if (vok !== want.voltage_ok) begin
        $error("voltage_ok: expected %0b, got %0b", want.voltage_ok, vok);
        mismatches++;
      end
      if (tok !== want.temperature_ok) begin
        $error("temperature_ok: expected %0b, got %0b", want.temperature_ok, tok);
        mismatches++;
      end
      if (mdm !== want.modem_on) begin
        $error("modem_on: expected %0b, got %0b", want.modem_on, mdm);
        mismatches++;
      end
      if (swo !== want.switch_on) begin
        $error("switch_on: expected %0b, got %0b", want.switch_on, swo);
        mismatches++;
      end
      if (up !== want.uptime_s) begin
        $error("uptime_s: expected %0d, got %0d", want.uptime_s, up);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_kind = '0;
  logic [15:0]       in_supply_mv = '0;
  logic [15:0]       in_battery_mv = '0;
  logic signed [7:0] in_temperature_c = '0;
  logic              in_enable = 1'b0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_power_state;
  logic              out_charging;
  logic              out_voltage_ok;
  logic              out_temperature_ok;
  logic              out_modem_on;
  logic              out_switch_on;
  logic [31:0]       out_uptime_s;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  monitor_status_board sb;
  reg_write_t          cfg_plan[$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  int          hold_cnt = 0;
  int          idle_cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned reg_writes = 0;

  supply_battery_power_state_monitor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_supply_mv       (in_supply_mv),
    .in_battery_mv      (in_battery_mv),
    .in_temperature_c   (in_temperature_c),
    .in_enable          (in_enable),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_power_state    (out_power_state),
    .out_charging       (out_charging),
    .out_voltage_ok     (out_voltage_ok),
    .out_temperature_ok (out_temperature_ok),
    .out_modem_on       (out_modem_on),
    .out_switch_on      (out_switch_on),
    .out_uptime_s       (out_uptime_s),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_status(out_power_state, out_charging, out_voltage_ok, out_temperature_ok,
                      out_modem_on, out_switch_on, out_uptime_s);
    if (hold_off) begin
      out_stall <= (hold_cnt < HOLD_CYCLES);
      if (hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
    end else begin
      hold_cnt  <= 0;
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("supply_battery_power_state_monitor regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input kind_t kind, input logic [15:0] vsup,
                              input logic [15:0] vbat, input logic signed [7:0] temp,
                              input logic en);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_supply_mv     <= vsup;
    in_battery_mv    <= vbat;
    in_temperature_c <= temp;
    in_enable        <= en;
    do @(posedge clk); while (in_stall);
    sb.take_request(kind, vsup, vbat, temp, en);
    requests_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic plan_limits(input logic [15:0] smin, input logic [15:0] smax,
                             input logic [15:0] bmin, input logic [15:0] bmax,
                             input logic signed [7:0] tlim, input logic [15:0] period);
    cfg_plan.push_back('{REG_SUPPLY_MIN, smin});
    cfg_plan.push_back('{REG_SUPPLY_MAX, smax});
    cfg_plan.push_back('{REG_BATTERY_MIN, bmin});
    cfg_plan.push_back('{REG_BATTERY_MAX, bmax});
    cfg_plan.push_back('{REG_TEMP_LIMIT, {{8{tlim[7]}}, tlim}});
    cfg_plan.push_back('{REG_TICK_PERIOD, period});
  endtask

  task automatic program_regs();
    reg_write_t w;
    while (cfg_plan.size() != 0) begin
      w = cfg_plan.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.index;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(w.index, w.data);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_random_limits(input logic [15:0] period);
    logic [15:0] smin, bmin;
    int          tl;
    smin = 16'($urandom_range(30000));
    bmin = 16'($urandom_range(20000, 1));
    tl   = int'($urandom_range(227)) - 100;
    plan_limits(smin, 16'(int'(smin) + int'($urandom_range(65535 - int'(smin)))),
                bmin, 16'(int'(bmin) + int'($urandom_range(65535 - int'(bmin)))),
                8'(tl), period);
  endtask

  // Ticks stay inside the windows in normal state; a share drops the
  // battery below its minimum, and in low battery some climb toward recovery.
  task automatic random_phase(input int count, input bit allow_shutdown);
    logic [31:0]       r1, r2;
    logic [15:0]       vsup, vbat;
    logic signed [7:0] temp;
    int                pick, t;
    repeat (count) begin
      r1   = $urandom;
      r2   = $urandom;
      vsup = r1[15:0];
      vbat = r1[31:16];
      temp = r2[7:0];
      pick = $urandom_range(99);
      if (allow_shutdown && pick < 8) begin
        send_request(KIND_SHUTDOWN, vsup, vbat, temp, r2[8]);
      end else if (pick < 20) begin
        send_request(KIND_MODEM, vsup, vbat, temp, r2[8]);
      end else if (pick < 32) begin
        send_request(KIND_SWITCH, vsup, vbat, temp, r2[8]);
      end else begin
        if (sb.mode == ST_NORMAL) begin
          if (sb.battery_min != 16'd0 && $urandom_range(11) == 0) begin
            vbat = 16'($urandom_range(int'(sb.battery_min) - 1, 0));
          end else begin
            vsup = 16'($urandom_range(sb.supply_max, sb.supply_min));
            vbat = 16'($urandom_range(sb.battery_max, sb.battery_min));
            t    = $urandom_range(int'(sb.temp_limit) + 127, 0);
            temp = 8'(t - 128);
          end
        end else if (sb.mode == ST_LOWBAT && r2[9]) begin
          t    = int'(sb.last_battery) + int'($urandom_range(300));
          vbat = (t > 65535) ? 16'hffff : 16'(t);
        end
        send_request(KIND_TICK, vsup, vbat, temp, r2[8]);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // level sets before any tick report zeroed flags
    send_request(KIND_MODEM, 16'd0, 16'd0, 8'sd0, 1'b1);
    send_request(KIND_SWITCH, 16'd0, 16'd0, 8'sd0, 1'b1);
    send_request(KIND_MODEM, 16'd0, 16'd0, 8'sd0, 1'b0);
    // first tick ignores temperature
    send_request(KIND_TICK, 16'd12000, 16'd3800, 8'sd127, 1'b0);
    send_request(KIND_TICK, 16'd12000, 16'd3820, 8'sd25, 1'b0);
    send_request(KIND_TICK, 16'd9000, 16'd4300, 8'sd84, 1'b0);
    send_request(KIND_TICK, 16'd16000, 16'd3300, -8'sd128, 1'b0);
    // temp fault and low battery together: low battery wins
    send_request(KIND_TICK, 16'd12000, 16'd3299, 8'sd127, 1'b0);
    send_request(KIND_TICK, 16'd12000, 16'd3500, 8'sd0, 1'b0);
    send_request(KIND_TICK, 16'd12000, 16'd3449, 8'sd0, 1'b0);
    send_request(KIND_TICK, 16'd12000, 16'd3501, 8'sd0, 1'b0);
    send_request(KIND_TICK, 16'd12000, 16'd3300, 8'sd0, 1'b0);
    send_request(KIND_MODEM, 16'hffff, 16'hffff, -8'sd1, 1'b1);
    send_request(KIND_SWITCH, 16'hffff, 16'hffff, -8'sd1, 1'b0);
    send_request(KIND_SWITCH, 16'd0, 16'd0, 8'sd0, 1'b1);

    random_phase(500, 1'b0);
    wait_idle();

    plan_random_limits(16'd1);
    program_regs();
    send_idle_pct = 83;
    random_phase(400, 1'b0);
    wait_idle();

    plan_limits(16'd0, 16'hffff, 16'd0, 16'hffff, 8'sd127, 16'hffff);
    program_regs();
    send_idle_pct = 0;
    recv_stall_pct <= 83;
    random_phase(400, 1'b0);
    wait_idle();

    // long output hold-off with the sender streaming
    hold_off <= 1'b1;
    random_phase(40, 1'b0);
    wait_idle();
    hold_off <= 1'b0;

    plan_random_limits(16'($urandom_range(65535, 1)));
    cfg_plan.push_back('{REG_SPARE_LO, 16'($urandom)});
    cfg_plan.push_back('{REG_SPARE_HI, 16'($urandom)});
    program_regs();
    send_idle_pct = 17;
    recv_stall_pct <= 17;
    random_phase(400, 1'b0);
    wait_idle();

    plan_limits(SUPPLY_MIN_RST, SUPPLY_MAX_RST, BATTERY_MIN_RST, BATTERY_MAX_RST,
                TEMP_LIMIT_RST, TICK_PERIOD_RST);
    program_regs();
    if (sb.mode == ST_LOWBAT) begin
      send_request(KIND_TICK, 16'd12000, 16'd0, 8'sd25, 1'b0);
      send_request(KIND_TICK, 16'd12000, 16'd4000, 8'sd25, 1'b0);
    end
    // supply fault from normal: error, sticky until the shutdown below
    send_request(KIND_TICK, 16'hffff, 16'd3800, 8'sd25, 1'b0);
    send_request(KIND_TICK, 16'd12000, 16'd3800, 8'sd25, 1'b0);
    wait_idle();

    plan_limits(16'd0, 16'hffff, 16'd0, 16'hffff, -8'sd128, 16'd0);
    program_regs();
    random_phase(80, 1'b0);
    send_request(KIND_SHUTDOWN, 16'd0, 16'd0, 8'sd0, 1'b1);
    send_request(KIND_MODEM, 16'd0, 16'd0, 8'sd0, 1'b1);
    send_request(KIND_SWITCH, 16'd0, 16'd0, 8'sd0, 1'b1);
    send_request(KIND_TICK, 16'd12000, 16'd3800, 8'sd25, 1'b0);
    random_phase(120, 1'b1);
    wait_idle();

    $display("Sent %0d requests and %0d register writes; checked %0d status results.",
             requests_sent, reg_writes, sb.results_seen);
    $display("Results by state: startup %0d, normal %0d, low battery %0d, error %0d, shutdown %0d",
             sb.per_state[0], sb.per_state[1], sb.per_state[2], sb.per_state[3],
             sb.per_state[4]);
    if (sb.mismatches == 0) begin
      $display("supply_battery_power_state_monitor regression: pass");
    end else begin
      $display("supply_battery_power_state_monitor regression: fail");
    end
    $finish;
  end

endmodule
